/* rtl/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher unit.
// Used by the channel interfaces and the top level. No dependencies.
package rc4_pkg;

  typedef logic [7:0] byte_t;

  // Size of the permutation and its last index.
  localparam int unsigned TABLE_SIZE = 256;
  localparam byte_t       LAST_IDX   = 8'hFF;

  // Codes of the kind field of a request.
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_K_RD,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_HOLD
  } rc4_state_e;

  // One result as it sits in the output register.
  typedef struct packed {
    byte_t out_byte;
    byte_t keystream_byte;
    logic  not_keyed;
  } res_t;

endpackage

/* rtl/rc4_in_if.sv */
// Input channel of the RC4 unit: valid/ready handshake with key or data payload.
// Depends on rc4_pkg for the byte type.
interface rc4_in_if;
  logic           valid;
  logic           ready;
  logic           kind;
  rc4_pkg::byte_t value;
  logic           last_key;

  modport source (output valid, output kind, output value, output last_key, input ready);
  modport sink   (input valid, input kind, input value, input last_key, output ready);
endinterface

/* rtl/rc4_out_if.sv */
// Output channel of the RC4 unit: valid/ready handshake with the result payload.
// Depends on rc4_pkg for the byte type.
interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t out_byte;
  rc4_pkg::byte_t keystream_byte;
  logic           not_keyed;

  modport source (output valid, output out_byte, output keystream_byte, output not_keyed,
                  input ready);
  modport sink   (input valid, input out_byte, input keystream_byte, input not_keyed,
                  output ready);
endinterface

/* rtl/rc4_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents. No dependencies.
module rc4_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/rc4_stream_cipher_unit.sv */
// RC4 stream cipher unit: key store, permutation memory and the sequencer that
// runs key scheduling and keystream generation. Depends on rc4_pkg, rc4_in_if,
// rc4_out_if and rc4_ram.
//
//   Channel  Dir  Payload                                 Moves
//   in_i     in   kind, value[7:0], last_key              one key or data request
//   out_o    out  out_byte[7:0], keystream_byte[7:0],     one result per data request
//                 not_keyed
//
// A key byte and a data byte before any key are taken in ST_IDLE. A keyed data
// byte then passes ST_RD_J, ST_WR_I and ST_WR_J: the single write port of the
// permutation memory serializes the two swap writes after the two dependent reads
// of S[i] and S[j]. The key byte marked last_key keeps the unit busy for an identity
// fill of 256 entries in ST_INIT, then 256 mixing steps from ST_K_RD to ST_WR_J.
// Reset clears all control state; both memories hold garbage until written.
// A full output register does not stop a request from being taken; a finished
// result then waits in a hold register until the output register frees.
module rc4_stream_cipher_unit #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rc4_in_if.sink     in_i,
  rc4_out_if.source  out_o
);
  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned CW  = $clog2(MAX_KEY_BYTES + 1);

  rc4_pkg::rc4_state_e state_q, state_d;
  rc4_pkg::byte_t      i_q, i_d, j_q, j_d;
  rc4_pkg::byte_t      si_q, si_d, sj_q, sj_d, t_q, t_d, val_q, val_d;
  logic [KAW-1:0]      kidx_q, kidx_d;
  logic [CW-1:0]       key_count_q, key_count_d;
  logic                keyed_q, keyed_d, sched_q, sched_d;
  logic                out_valid_q, out_valid_d;
  rc4_pkg::res_t       out_q, out_d, res_q, res_d, res_now;
  logic                res_ld;

  logic                perm_we;
  rc4_pkg::byte_t      perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic                key_we;
  rc4_pkg::byte_t      key_rdata;

  logic                in_acc, can_load;
  rc4_pkg::byte_t      j_sum, ks;

  // Permutation memory.
  rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::TABLE_SIZE)) u_perm (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_wdata),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  // Key store, written at the fill count and read at the cyclic key index.
  rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_count_q[KAW-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (kidx_q),
    .rdata_o (key_rdata)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign can_load = !out_valid_q || out_o.ready;

  // New j: the key byte is added only while scheduling.
  assign j_sum = j_q + perm_rdata + (sched_q ? key_rdata : 8'd0);

  // Keystream byte, forwarding the swapped values when t hits i or j.
  always_comb begin
    if (t_q == i_q) begin
      ks = sj_q;
    end else if (t_q == j_q) begin
      ks = si_q;
    end else begin
      ks = perm_rdata;
    end
  end

  // Sequencer: next state, memory accesses and result loading.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    val_d       = val_q;
    kidx_d      = kidx_q;
    key_count_d = key_count_q;
    keyed_d     = keyed_q;
    sched_d     = sched_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    perm_we     = 1'b0;
    perm_waddr  = i_q;
    perm_wdata  = perm_rdata;
    perm_raddr  = i_q;
    key_we      = 1'b0;
    res_now     = '0;
    res_ld      = 1'b0;
    in_i.ready  = (state_q == rc4_pkg::ST_IDLE);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        perm_raddr = i_q + 8'd1;
        if (in_acc) begin
          if (in_i.kind == rc4_pkg::KIND_KEY) begin
            if (key_count_q < CW'(MAX_KEY_BYTES)) begin
              key_we      = 1'b1;
              key_count_d = key_count_q + CW'(1);
            end
            if (in_i.last_key) begin
              sched_d = 1'b1;
              i_d     = '0;
              j_d     = '0;
              kidx_d  = '0;
              state_d = rc4_pkg::ST_INIT;
            end
          end else if (!keyed_q) begin
            res_now.out_byte       = in_i.value;
            res_now.keystream_byte = '0;
            res_now.not_keyed      = 1'b1;
            res_ld                 = 1'b1;
          end else begin
            i_d     = i_q + 8'd1;
            val_d   = in_i.value;
            state_d = rc4_pkg::ST_RD_J;
          end
        end
      end
      rc4_pkg::ST_INIT: begin
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = i_q;
        i_d        = i_q + 8'd1;
        if (i_q == rc4_pkg::LAST_IDX) begin
          state_d = rc4_pkg::ST_K_RD;
        end
      end
      rc4_pkg::ST_K_RD: begin
        perm_raddr = i_q;
        state_d    = rc4_pkg::ST_RD_J;
      end
      rc4_pkg::ST_RD_J: begin
        si_d       = perm_rdata;
        j_d        = j_sum;
        perm_raddr = j_sum;
        state_d    = rc4_pkg::ST_WR_I;
      end
      rc4_pkg::ST_WR_I: begin
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rdata;
        sj_d       = perm_rdata;
        t_d        = si_q + perm_rdata;
        perm_raddr = si_q + perm_rdata;
        state_d    = rc4_pkg::ST_WR_J;
      end
      rc4_pkg::ST_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = si_q;
        if (sched_q) begin
          i_d    = i_q + 8'd1;
          kidx_d = (CW'(kidx_q) + CW'(1) == key_count_q) ? '0 : kidx_q + KAW'(1);
          if (i_q == rc4_pkg::LAST_IDX) begin
            sched_d     = 1'b0;
            keyed_d     = 1'b1;
            key_count_d = '0;
            j_d         = '0;
            state_d     = rc4_pkg::ST_IDLE;
          end else begin
            state_d = rc4_pkg::ST_K_RD;
          end
        end else begin
          res_now.out_byte       = val_q ^ ks;
          res_now.keystream_byte = ks;
          res_now.not_keyed      = 1'b0;
          res_ld                 = 1'b1;
          state_d                = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_HOLD: begin
        if (can_load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rc4_pkg::ST_IDLE;
      end
    endcase

    // A finished result goes to the output register, or waits if it is full.
    if (res_ld) begin
      if (can_load) begin
        out_d       = res_now;
        out_valid_d = 1'b1;
      end else begin
        res_d   = res_now;
        state_d = rc4_pkg::ST_HOLD;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      kidx_q      <= '0;
      key_count_q <= '0;
      keyed_q     <= 1'b0;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kidx_q      <= kidx_d;
      key_count_q <= key_count_d;
      keyed_q     <= keyed_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    t_q   <= t_d;
    val_q <= val_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_q.out_byte;
  assign out_o.keystream_byte = out_q.keystream_byte;
  assign out_o.not_keyed      = out_q.not_keyed;

  // The key store never counts past its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= CW'(MAX_KEY_BYTES))
    else $error("key count beyond key store depth");

  // A held result only exists while the output register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rc4_pkg::ST_HOLD |-> out_valid_q)
    else $error("result held with free output register");

  // The end of scheduling leaves a keyed engine with an empty key store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sched_q) |-> keyed_q && key_count_q == '0 && i_q == '0 && j_q == '0)
    else $error("scheduling ended in a bad state");

  // The permutation is never written while waiting for a request or a free output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_we |-> state_q != rc4_pkg::ST_IDLE && state_q != rc4_pkg::ST_HOLD)
    else $error("permutation written outside a step");

  // A keyed data request advances i by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.kind == rc4_pkg::KIND_DATA && keyed_q |=> i_q == $past(i_q) + 8'd1)
    else $error("index i did not advance");
endmodule
